// File: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted keymap table: shared package
// Types, codes and constants used by the cell chain and its controller.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Request modes
  typedef enum logic [1:0] {
    MODE_SET_SCAN = 2'd0,
    MODE_SET_IDX  = 2'd1,
    MODE_GET_SCAN = 2'd2,
    MODE_GET_IDX  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  // Keycodes that remove an entry when set
  localparam logic [9:0] KC_NULL     = 10'd0;
  localparam logic [9:0] KC_UNMAPPED = 10'd240;

  // Operation applied to the whole chain in the update cycle
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  // One table entry
  typedef struct packed {
    logic [31:0] sc;
    logic [9:0]  kc;
  } ent_t;

  // Entry picked out by one cell, zero when not selected
  typedef struct packed {
    logic hit;
    logic eq;
    ent_t ent;
  } tap_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic cmp_en;   // register compare flags
    logic tap_en;   // register selected entry
    logic by_scan;  // select by sorted boundary instead of position
    op_t  op;       // shift / write operation
    ent_t ent;      // search key and new entry data
  } cell_cmd_t;

endpackage

// File: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// Sorted keymap table: storage cell
// Holds one entry, compares it against the broadcast key, offers it to the
// result tree when selected and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module skt_cell #(
  parameter int PW       = 8,
  parameter int CW       = 9,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  skt_pkg::cell_cmd_t cmd,
  input  logic [PW-1:0]      pos,
  input  logic [CW-1:0]      count,
  input  skt_pkg::ent_t      dn_ent,   // entry of the cell below
  input  skt_pkg::ent_t      up_ent,   // entry of the cell above
  input  logic               lt_prev,  // cell below holds a smaller key
  output skt_pkg::ent_t      ent_o,
  output logic               lt_o,
  output skt_pkg::tap_t      tap_o,
  output logic [PW-1:0]      tpos_o
);
  import skt_pkg::*;

  localparam logic [PW-1:0] MY_POS = PW'(CELL_IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(CELL_IDX);

  ent_t          ent_r, ent_nxt;
  logic          lt_r, lt_nxt;
  logic          eq_r, eq_nxt;
  tap_t          tap_r, tap_nxt;
  logic [PW-1:0] tpos_r, tpos_nxt;
  logic          valid;
  logic          sel;

  assign valid = (MY_CNT < count);

  // Compare stage
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmd.cmp_en) begin
      lt_nxt = valid && (ent_r.sc < cmd.ent.sc);
      eq_nxt = valid && (ent_r.sc == cmd.ent.sc);
    end
  end

  // Select stage: first cell not below the key, or the addressed position
  assign sel = cmd.by_scan ? (lt_prev && !lt_r) : (pos == MY_POS);

  always_comb begin
    tap_nxt  = tap_r;
    tpos_nxt = tpos_r;
    if (cmd.tap_en) begin
      tap_nxt  = '0;
      tpos_nxt = '0;
      if (sel) begin
        tap_nxt.hit = 1'b1;
        tap_nxt.eq  = eq_r;
        tap_nxt.ent = ent_r;
        tpos_nxt    = MY_POS;
      end
    end
  end

  // Update stage: shift up on insert, down on delete, or rewrite keycode
  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_WRITE: begin
        if (MY_POS == pos) ent_nxt.kc = cmd.ent.kc;
      end
      OP_INSERT: begin
        if (MY_POS > pos) ent_nxt = dn_ent;
        else if (MY_POS == pos) ent_nxt = cmd.ent;
      end
      OP_DELETE: begin
        if (MY_POS >= pos) ent_nxt = up_ent;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    lt_r   <= lt_nxt;
    eq_r   <= eq_nxt;
    tap_r  <= tap_nxt;
    tpos_r <= tpos_nxt;
  end

  assign ent_o  = ent_r;
  assign lt_o   = lt_r;
  assign tap_o  = tap_r;
  assign tpos_o = tpos_r;

endmodule

// File: rtl/sorted_keymap_table_core.sv
// ----------------------------------------------------------------------------
// Sorted keymap table core
// Scancode to keycode table kept in ascending scancode order in a chain of
// cells; set, delete and lookup by scancode or by position.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  in_     | in  | in_tvalid/tready   | tuser mode, tdata scancode/index/key
//  out_    | out | out_tvalid/tready  | tdata status .. entry_count
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data scan mask
//
//  Each request steps through compare, select, group OR, decide and update
//  in the cell chain, then loads the output register.
//  A new request is taken once the previous one has reached the output
//  register; a stalled output holds the core in its final state.
//  Reset clears the entry count; cell contents are only read below it.
// ----------------------------------------------------------------------------
module sorted_keymap_table_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // request: [31:0] scancode, [39:32] index, [49:40] keycode
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [55:0]        in_tdata,
  input  skt_pkg::mode_t     in_tuser,   // [1:0] mode
  // result: [1:0] status, [2] found, [10:3] entry_index, [20:11] key_value,
  //         [52:21] entry_scancode, [61:53] entry_count
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  // scan mask register
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import skt_pkg::*;

  localparam int PW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int G  = 16;
  localparam int NG = (TABLE_ENTRIES + G - 1) / G;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,
    S_SEL  = 7'b0000100,
    S_GRP  = 7'b0001000,
    S_DEC  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   mask_r;
  mode_t         mode_r;
  logic [31:0]   key_r;
  logic [9:0]    kc_r;
  logic [7:0]    idx_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] cnt_res_r, cnt_res_nxt;
  op_t           op_r, op_nxt;
  status_t       stat_r, stat_nxt;
  logic          found_r, found_nxt;
  logic [7:0]    eidx_r, eidx_nxt;
  logic [9:0]    kv_r, kv_nxt;
  logic [31:0]   esc_r, esc_nxt;
  logic          out_tvalid_r;
  logic [63:0]   out_tdata_r;

  logic          in_acc;
  logic          out_free;
  logic [31:0]   in_sc;
  logic [PW+7:0] in_idx_x;
  cell_cmd_t     cmd;

  ent_t          ent_w  [TABLE_ENTRIES];
  logic          lt_w   [TABLE_ENTRIES];
  tap_t          tap_w  [TABLE_ENTRIES];
  logic [PW-1:0] tpos_w [TABLE_ENTRIES];
  tap_t          grp_r     [NG];
  logic [PW-1:0] grp_pos_r [NG];
  tap_t          red;
  logic [PW-1:0] red_pos;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_sc     = in_tdata[31:0];
  assign in_idx_x  = {{PW{1'b0}}, in_tdata[39:32]};

  // Scan mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // Request capture, masking the key for set by scancode
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser;
      kc_r   <= in_tdata[49:40];
      idx_r  <= in_tdata[39:32];
      if (in_tuser == MODE_SET_SCAN && mask_r != 32'd0) key_r <= in_sc & mask_r;
      else key_r <= in_sc;
    end
  end

  // Broadcast command to the chain
  always_comb begin
    cmd         = '0;
    cmd.cmp_en  = (state_r == S_CMP);
    cmd.tap_en  = (state_r == S_SEL);
    cmd.by_scan = (mode_r == MODE_SET_SCAN) || (mode_r == MODE_GET_SCAN);
    cmd.op      = (state_r == S_UPD) ? op_r : OP_NONE;
    cmd.ent.sc  = key_r;
    cmd.ent.kc  = kc_r;
  end

  // Cell chain
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ent_t dn_e;
    ent_t up_e;
    logic lt_p;
    if (i == 0) begin : g_first
      assign dn_e = cmd.ent;
      assign lt_p = 1'b1;
    end else begin : g_mid
      assign dn_e = ent_w[i-1];
      assign lt_p = lt_w[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign up_e = ent_w[i];
    end else begin : g_inner
      assign up_e = ent_w[i+1];
    end
    skt_cell #(
      .PW       (PW),
      .CW       (CW),
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (pos_r),
      .count   (count_r),
      .dn_ent  (dn_e),
      .up_ent  (up_e),
      .lt_prev (lt_p),
      .ent_o   (ent_w[i]),
      .lt_o    (lt_w[i]),
      .tap_o   (tap_w[i]),
      .tpos_o  (tpos_w[i])
    );
  end

  // Result tree, first level: OR of each group of cells, registered
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      tap_t          acc;
      logic [PW-1:0] accp;
      acc  = '0;
      accp = '0;
      for (int j = 0; j < G; j++) begin
        if (g * G + j < TABLE_ENTRIES) begin
          acc  = acc | tap_w[g * G + j];
          accp = accp | tpos_w[g * G + j];
        end
      end
      grp_r[g]     <= acc;
      grp_pos_r[g] <= accp;
    end
  end

  // Result tree, final level
  always_comb begin
    red     = '0;
    red_pos = '0;
    for (int g = 0; g < NG; g++) begin
      red     = red | grp_r[g];
      red_pos = red_pos | grp_pos_r[g];
    end
  end

  // Decision: result fields and chain operation
  always_comb begin
    logic          del;
    logic          in_range;
    logic [CW+7:0] idx_c;
    logic [CW+7:0] cnt_c;
    logic [PW+7:0] rpos_x;
    del       = (kc_r == KC_NULL) || (kc_r == KC_UNMAPPED);
    idx_c     = {{CW{1'b0}}, idx_r};
    cnt_c     = {8'b0, count_r};
    in_range  = idx_c < cnt_c;
    rpos_x    = {8'b0, red_pos};
    pos_nxt   = pos_r;
    op_nxt    = OP_NONE;
    cnt_res_nxt = count_r;
    stat_nxt  = ST_OK;
    found_nxt = 1'b0;
    eidx_nxt  = '0;
    kv_nxt    = '0;
    esc_nxt   = '0;
    case (mode_r)
      MODE_SET_SCAN: begin
        if (red.hit && red.eq) begin
          pos_nxt   = red_pos;
          found_nxt = 1'b1;
          eidx_nxt  = rpos_x[7:0];
          kv_nxt    = red.ent.kc;
          esc_nxt   = red.ent.sc;
          op_nxt    = del ? OP_DELETE : OP_WRITE;
          cnt_res_nxt = del ? count_r - CW'(1) : count_r;
        end else if (count_r == FULL_CNT) begin
          stat_nxt = ST_FULL;
        end else begin
          // new entry; a delete of it leaves the table as it was
          pos_nxt   = red_pos;
          found_nxt = 1'b1;
          eidx_nxt  = rpos_x[7:0];
          esc_nxt   = key_r;
          op_nxt    = del ? OP_NONE : OP_INSERT;
          cnt_res_nxt = del ? count_r : count_r + CW'(1);
        end
      end
      MODE_SET_IDX: begin
        if (!in_range) begin
          stat_nxt = ST_RANGE;
        end else begin
          found_nxt = 1'b1;
          eidx_nxt  = idx_r;
          kv_nxt    = red.ent.kc;
          esc_nxt   = red.ent.sc;
          op_nxt    = del ? OP_DELETE : OP_WRITE;
          cnt_res_nxt = del ? count_r - CW'(1) : count_r;
        end
      end
      MODE_GET_SCAN: begin
        if (red.hit && red.eq) begin
          found_nxt = 1'b1;
          eidx_nxt  = rpos_x[7:0];
          kv_nxt    = red.ent.kc;
          esc_nxt   = red.ent.sc;
        end
      end
      MODE_GET_IDX: begin
        if (!in_range) begin
          stat_nxt = ST_RANGE;
        end else begin
          found_nxt = 1'b1;
          eidx_nxt  = idx_r;
          kv_nxt    = red.ent.kc;
          esc_nxt   = red.ent.sc;
        end
      end
      default: stat_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= in_idx_x[PW-1:0];
    end else if (state_r == S_DEC) begin
      pos_r <= pos_nxt;
    end
    if (state_r == S_DEC) begin
      op_r      <= op_nxt;
      cnt_res_r <= cnt_res_nxt;
      stat_r    <= stat_nxt;
      found_r   <= found_nxt;
      eidx_r    <= eidx_nxt;
      kv_r      <= kv_nxt;
      esc_r     <= esc_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_GRP;
      S_GRP:   state_nxt = S_DEC;
      S_DEC:   state_nxt = S_UPD;
      S_UPD:   state_nxt = out_free ? S_IDLE : S_WAIT;
      S_WAIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD) count_r <= cnt_res_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    logic [CW+8:0] cnt_x;
    cnt_x = {9'b0, cnt_res_r};
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_UPD || state_r == S_WAIT) && out_free) begin
      out_tvalid_r <= 1'b1;
      out_tdata_r  <= {2'b0, cnt_x[8:0], esc_r, kv_r, eidx_r, found_r, stat_r};
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT)
    else $error("entry count above table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_UPD) |=> $stable(count_r))
    else $error("entry count changed outside the update cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CMP) && !in_tready)
    else $error("request not followed by compare cycle");

endmodule
